// ===== rtl/core/cmif_pkg.sv =====
// Shared constants for the cross median image filter.
// No dependencies; imported by cmif_median5 and the top level.
package cmif_pkg;

   // Operand count of the cross neighborhood: up, left, center, right, down.
   localparam int CROSS_TAPS = 5;

   // Input word kinds carried on req_tuser.
   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_FLUSH = 1'b1;

   // Configuration register indexes.
   localparam logic CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic CSR_IMAGE_HEIGHT = 1'b1;

   localparam int CSR_DATA_W = 16;
   localparam int IMG_WIDTH_W = 11;
   localparam int IMG_HEIGHT_W = 16;

   typedef logic [IMG_WIDTH_W-1:0]  img_width_type;
   typedef logic [IMG_HEIGHT_W-1:0] img_height_type;

   localparam img_width_type  IMG_WIDTH_RESET  = 11'd640;
   localparam img_height_type IMG_HEIGHT_RESET = 16'd480;

endpackage

// ===== rtl/core/cmif_line_ram.sv =====
// Line store: one write port, one read port, registered read data.
// Write-first on an address match so a same-cycle update is forwarded.
module cmif_line_ram #(
   parameter int DEPTH  = 1024,
   parameter int DATA_W = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_W-1:0]        wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DATA_W-1:0]        rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (wr_en && (wr_addr == rd_addr)) begin
         rd_data_ff <= wr_data;
      end else begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/cmif_median5.sv =====
// Five-input median network and the result output register.
// Depends on cmif_pkg for the tap count.
module cmif_median5 #(
   parameter int PIXEL_BITS = 8
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   in_valid,
   output logic                                   in_ready,
   input  logic [cmif_pkg::CROSS_TAPS-1:0][PIXEL_BITS-1:0] in_taps,
   input  logic                                   in_last,
   output logic                                   out_valid,
   input  logic                                   out_ready,
   output logic [PIXEL_BITS-1:0]                  out_median,
   output logic                                   out_last
);
   import cmif_pkg::*;

   logic [CROSS_TAPS-1:0][PIXEL_BITS-1:0] v;
   logic [PIXEL_BITS-1:0] t;
   logic                  valid_ff;
   logic                  valid_in;
   logic [PIXEL_BITS-1:0] median_ff;
   logic                  last_ff;

   // Seven compare-exchange steps; the middle slot ends up holding the median.
   always_comb begin
      v = in_taps;
      t = '0;
      if (v[0] > v[1]) begin t = v[0]; v[0] = v[1]; v[1] = t; end
      if (v[3] > v[4]) begin t = v[3]; v[3] = v[4]; v[4] = t; end
      if (v[0] > v[3]) begin t = v[0]; v[0] = v[3]; v[3] = t; end
      if (v[1] > v[4]) begin t = v[1]; v[1] = v[4]; v[4] = t; end
      if (v[1] > v[2]) begin t = v[1]; v[1] = v[2]; v[2] = t; end
      if (v[2] > v[3]) begin t = v[2]; v[2] = v[3]; v[3] = t; end
      if (v[1] > v[2]) begin t = v[1]; v[1] = v[2]; v[2] = t; end
   end

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      valid_in = valid_ff;
      if (in_valid && in_ready) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         median_ff <= v[2];
         last_ff   <= in_last;
      end
   end

   assign out_valid  = valid_ff;
   assign out_median = median_ff;
   assign out_last   = last_ff;

endmodule

// ===== rtl/core/cross_median_image_filter_top.sv =====
// Top level of the five-point cross median image filter.
// Depends on cmif_pkg, cmif_line_ram and cmif_median5.
//
//   channel | direction | words                         | handshake
//   --------+-----------+-------------------------------+----------------------
//   req_    | in        | pixel or flush tick           | req_tvalid/req_tready
//   rsp_    | out       | median, last-of-image flag    | rsp_tvalid/rsp_tready
//   csr_    | in        | register index + write data   | csr_valid/csr_ready
//
// One input word per clock, sustained while rsp_ is not stalled. For each
// word that causes a result, the cross operands are gathered from the line
// stores into the operand stage, then pass through the median network into
// the output register. Line store reads are issued from the next column
// count, so each store's single read port keeps pace with one word per clock.
// Reset (synchronous, active high) clears counters, window and pipeline
// valids; the line stores are not cleared and hold no meaning until written.
// A stalled rsp_ side still lets words in until one loads the operand stage.
module cross_median_image_filter_top #(
   parameter int MAX_WIDTH  = 1024,
   parameter int PIXEL_BITS = 8
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // request stream
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [((PIXEL_BITS+7)/8)*8-1:0]        req_tdata,  // [PIXEL_BITS-1:0] pixel
   input  logic                                   req_tuser,  // [0] op (1 = flush tick)
   // result stream
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [((PIXEL_BITS+7)/8)*8-1:0]        rsp_tdata,  // [PIXEL_BITS-1:0] filtered
   output logic                                   rsp_tlast,  // last_of_image
   // configuration writes
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic                                   csr_index,
   input  logic [cmif_pkg::CSR_DATA_W-1:0]        csr_data
);
   import cmif_pkg::*;

   localparam int DATA_W = ((PIXEL_BITS + 7) / 8) * 8;
   localparam int CNT_W  = $clog2(MAX_WIDTH);
   localparam int EW     = (CNT_W + 1 > IMG_WIDTH_W) ? CNT_W + 1 : IMG_WIDTH_W;

   // ---------------- configuration ----------------
   img_width_type  img_width_ff;
   img_height_type img_height_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         img_width_ff  <= IMG_WIDTH_RESET;
         img_height_ff <= IMG_HEIGHT_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:  img_width_ff  <= csr_data[IMG_WIDTH_W-1:0];
            CSR_IMAGE_HEIGHT: img_height_ff <= csr_data[IMG_HEIGHT_W-1:0];
            default: ;
         endcase
      end
   end

   // Effective width: zero counts as one, clamped to the line store depth.
   logic [EW-1:0]    width_ext;
   logic [CNT_W:0]   eff_width;
   img_height_type   eff_height;

   assign width_ext = EW'(img_width_ff);

   always_comb begin
      if (width_ext == '0) begin
         eff_width = (CNT_W+1)'(1);
      end else if (width_ext > EW'(MAX_WIDTH)) begin
         eff_width = (CNT_W+1)'(MAX_WIDTH);
      end else begin
         eff_width = width_ext[CNT_W:0];
      end
   end

   assign eff_height = (img_height_ff == '0) ? img_height_type'(1) : img_height_ff;

   // ---------------- position counters and window ----------------
   logic [CNT_W-1:0]      col_ff, col_in;
   img_height_type        row_ff, row_in;
   logic [PIXEL_BITS-1:0] win_c_ff, win_c_in;   // center of the previous step
   logic [PIXEL_BITS-1:0] win_r_ff, win_r_in;   // right of the previous step
   logic [PIXEL_BITS-1:0] mid0_ff;              // copy of middle line entry 0

   logic [CNT_W:0]        col_plus1;
   logic                  last_col;
   logic                  flushing;
   logic                  emit;
   logic                  up_ok;
   logic                  accept;
   logic                  in_flush;
   logic                  step;       // accepted word that advances the state
   logic                  line_we;

   logic [PIXEL_BITS-1:0] pixel;
   logic [PIXEL_BITS-1:0] up_rd, mid_rd;
   logic [PIXEL_BITS-1:0] t_up, t_left, t_center, t_right, t_down;

   assign pixel     = req_tdata[PIXEL_BITS-1:0];
   assign col_plus1 = {1'b0, col_ff} + (CNT_W+1)'(1);
   assign last_col  = col_plus1 >= eff_width;
   assign flushing  = row_ff >= eff_height;
   assign emit      = flushing || (row_ff != '0);
   assign up_ok     = flushing ? (eff_height >= img_height_type'(2))
                               : (row_ff >= img_height_type'(2));

   assign accept   = req_tvalid && req_tready;
   assign in_flush = (req_tuser == OP_FLUSH);
   // A flush tick during the image, or a pixel while flushing, is dropped.
   assign step     = accept && (in_flush == flushing);
   assign line_we  = step && !flushing && !reset;

   // Cross operands; everything outside the image reads as zero.
   assign t_left   = (col_ff == '0) ? '0 : win_c_ff;
   assign t_center = (col_ff == '0) ? mid0_ff : win_r_ff;
   assign t_right  = last_col ? '0 : mid_rd;
   assign t_up     = (emit && up_ok) ? up_rd : '0;
   assign t_down   = flushing ? '0 : pixel;

   always_comb begin
      col_in   = col_ff;
      row_in   = row_ff;
      win_c_in = win_c_ff;
      win_r_in = win_r_ff;
      if (step) begin
         win_c_in = t_center;
         win_r_in = t_right;
         if (last_col) begin
            col_in = '0;
            row_in = flushing ? '0 : row_ff + img_height_type'(1);
         end else begin
            col_in = col_plus1[CNT_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff   <= '0;
         row_ff   <= '0;
         win_c_ff <= '0;
         win_r_ff <= '0;
      end else begin
         col_ff   <= col_in;
         row_ff   <= row_in;
         win_c_ff <= win_c_in;
         win_r_ff <= win_r_in;
      end
   end

   always_ff @(posedge clock) begin
      if (line_we && (col_ff == '0)) begin
         mid0_ff <= t_down;
      end
   end

   // ---------------- line stores ----------------
   // Reads target the column of the next word: upper at that column, middle one
   // to its right. Write-first forwarding covers narrow images where the next
   // read hits the entry written in the same cycle.
   logic [CNT_W-1:0] rd_col;
   logic [CNT_W-1:0] rd_col_right;

   assign rd_col       = reset ? '0 : col_in;
   assign rd_col_right = (rd_col == CNT_W'(MAX_WIDTH - 1)) ? '0 : rd_col + CNT_W'(1);

   cmif_line_ram #(
      .DEPTH  (MAX_WIDTH),
      .DATA_W (PIXEL_BITS)
   ) u_upper_line (
      .clock   (clock),
      .wr_en   (line_we),
      .wr_addr (col_ff),
      .wr_data (t_center),     // the middle row entry moves up
      .rd_addr (rd_col),
      .rd_data (up_rd)
   );

   cmif_line_ram #(
      .DEPTH  (MAX_WIDTH),
      .DATA_W (PIXEL_BITS)
   ) u_middle_line (
      .clock   (clock),
      .wr_en   (line_we),
      .wr_addr (col_ff),
      .wr_data (t_down),
      .rd_addr (rd_col_right),
      .rd_data (mid_rd)
   );

   // ---------------- operand stage ----------------
   logic                                  ops_valid_ff, ops_valid_in;
   logic [CROSS_TAPS-1:0][PIXEL_BITS-1:0] ops_taps_ff;
   logic                                  ops_last_ff;
   logic                                  med_ready;
   logic                                  load_ops;

   assign req_tready = !ops_valid_ff || med_ready;
   assign load_ops   = step && emit;

   always_comb begin
      ops_valid_in = ops_valid_ff;
      if (load_ops) begin
         ops_valid_in = 1'b1;
      end else if (med_ready) begin
         ops_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ops_valid_ff <= 1'b0;
      end else begin
         ops_valid_ff <= ops_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_ops) begin
         ops_taps_ff <= {t_down, t_right, t_center, t_left, t_up};
         ops_last_ff <= flushing && last_col;
      end
   end

   // ---------------- median and output register ----------------
   logic [PIXEL_BITS-1:0] filtered;

   cmif_median5 #(
      .PIXEL_BITS (PIXEL_BITS)
   ) u_median5 (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (ops_valid_ff),
      .in_ready   (med_ready),
      .in_taps    (ops_taps_ff),
      .in_last    (ops_last_ff),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_median (filtered),
      .out_last   (rsp_tlast)
   );

   assign rsp_tdata = DATA_W'(filtered);

endmodule
